### rtl/pcbc_pkg.sv
// Shared types and constants for the pulse channel burst counter.
package pcbc_pkg;

	localparam int MASK_W    = 7;
	localparam int CHAN_W    = 3;
	localparam int WIDTH_W   = 16;
	localparam int TICK_W    = 8;
	localparam int TIME_W    = 32;
	localparam int COUNT_W   = 16;
	localparam int TOTAL_W   = 32;
	localparam int REGEN_W   = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUIET      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PASSTHRU   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TEST_MODE  = 3'd5;

	localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST = 16'd20;
	localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST = 16'd250;
	localparam logic [TICK_W-1:0]  DEBOUNCE_RST  = 8'd2;
	localparam logic [TICK_W-1:0]  QUIET_RST     = 8'd100;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [WIDTH_W-1:0] min_width_ms;
		logic [WIDTH_W-1:0] max_width_ms;
		logic [TICK_W-1:0]  debounce_ticks;
		logic [TICK_W-1:0]  quiet_ticks;
		logic               passthru_enable;
		logic               test_mode;
	} cfg_t;

	typedef struct packed {
		logic              counted;
		logic [CHAN_W-1:0] channel;
	} count_ev_t;

	typedef struct packed {
		logic               pulse_counted;
		logic               burst_done;
		logic [CHAN_W-1:0]  done_channel;
		logic [COUNT_W-1:0] done_pulses;
		logic [TOTAL_W-1:0] done_total;
		logic [REGEN_W-1:0] regen_edges;
	} result_t;

endpackage

### rtl/pcbc_debounce.sv
// Mask debouncer, press timing and pulse width qualification.
module pcbc_debounce #(
	parameter int NUM_CHANNELS = 7
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic [pcbc_pkg::TIME_W-1:0]         now_ms,
	input  logic [pcbc_pkg::MASK_W-1:0]         active_mask,
	input  pcbc_pkg::cfg_t                      cfg,
	output pcbc_pkg::count_ev_t                 ev
);

	logic [pcbc_pkg::MASK_W-1:0]  settled_q, change_q;
	logic                         was_press_q;
	logic [pcbc_pkg::TICK_W-1:0]  left_q;
	logic [pcbc_pkg::WIDTH_W-1:0] press_time_q;
	logic [pcbc_pkg::CHAN_W-1:0]  pressed_q;

	logic [pcbc_pkg::MASK_W-1:0]  settled_d, change_d;
	logic                         was_press_d;
	logic [pcbc_pkg::TICK_W-1:0]  left_d, left_dec;
	logic [pcbc_pkg::WIDTH_W-1:0] press_time_d, width;
	logic [pcbc_pkg::CHAN_W-1:0]  pressed_d, match_chan;
	logic                         width_ok;

	always_comb begin
		match_chan = '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (change_q == pcbc_pkg::MASK_W'(1 << i))
				match_chan = pcbc_pkg::CHAN_W'(i + 1);
		end
	end

	assign width    = now_ms[pcbc_pkg::WIDTH_W-1:0] - press_time_q;
	assign width_ok = (width > cfg.min_width_ms) && (width < cfg.max_width_ms);
	assign left_dec = left_q - 8'd1;

	always_comb begin
		settled_d    = settled_q;
		change_d     = change_q;
		was_press_d  = was_press_q;
		left_d       = left_q;
		press_time_d = press_time_q;
		pressed_d    = pressed_q;
		ev           = '0;
		if (settled_q != active_mask) begin
			change_d    = settled_q ^ active_mask;
			was_press_d = |((settled_q ^ active_mask) & active_mask);
			settled_d   = active_mask;
			left_d      = cfg.debounce_ticks;
		end else if (left_q != '0) begin
			left_d = left_dec;
			if (left_dec == '0) begin
				if (was_press_q) begin
					press_time_d = now_ms[pcbc_pkg::WIDTH_W-1:0];
					pressed_d    = '0;
				end else if (width_ok) begin
					pressed_d = match_chan;
				end
				// a stale channel counts again on a release whose width falls outside the window
				ev.counted = (pressed_d != '0);
				ev.channel = pressed_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settled_q    <= '0;
			change_q     <= '0;
			was_press_q  <= 1'b0;
			left_q       <= '0;
			press_time_q <= '0;
			pressed_q    <= '0;
		end else if (adv) begin
			settled_q    <= settled_d;
			change_q     <= change_d;
			was_press_q  <= was_press_d;
			left_q       <= left_d;
			press_time_q <= press_time_d;
			pressed_q    <= pressed_d;
		end
	end

endmodule

### rtl/pcbc_burst.sv
// Quiet timer, burst count and per-channel running totals.
module pcbc_burst #(
	parameter int NUM_CHANNELS = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  pcbc_pkg::cfg_t       cfg,
	input  pcbc_pkg::count_ev_t  ev,
	output pcbc_pkg::result_t    res
);

	logic [pcbc_pkg::TICK_W-1:0]  quiet_q, quiet_d, quiet_dec;
	logic [pcbc_pkg::COUNT_W-1:0] count_q, count_d, count_base;
	logic [pcbc_pkg::CHAN_W-1:0]  chan_q, chan_d;
	logic [pcbc_pkg::TOTAL_W-1:0] totals_q [NUM_CHANNELS];
	logic [pcbc_pkg::TOTAL_W-1:0] old_total, new_total;
	logic                         done, in_range;

	assign quiet_dec = quiet_q - 8'd1;
	assign done      = (quiet_q != '0) && (quiet_dec == '0);
	assign in_range  = (chan_q != '0) && (32'(chan_q) <= 32'(NUM_CHANNELS));

	always_comb begin
		old_total = '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (chan_q == pcbc_pkg::CHAN_W'(i + 1))
				old_total = totals_q[i];
		end
	end

	assign new_total  = old_total + pcbc_pkg::TOTAL_W'(count_q);
	assign count_base = done ? '0 : count_q;

	always_comb begin
		count_d = count_base;
		chan_d  = chan_q;
		quiet_d = (quiet_q != '0) ? quiet_dec : quiet_q;
		if (ev.counted) begin
			if (count_base != pcbc_pkg::COUNT_MAX)
				count_d = count_base + 16'd1;
			quiet_d = cfg.quiet_ticks;
			chan_d  = ev.channel;
		end
	end

	always_comb begin
		res               = '0;
		res.pulse_counted = ev.counted;
		if (done) begin
			res.burst_done   = 1'b1;
			res.done_channel = chan_q;
			res.done_pulses  = count_q;
			res.done_total   = in_range ? new_total : '0;
			if (cfg.passthru_enable && !cfg.test_mode)
				res.regen_edges = {count_q, 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_q <= '0;
			count_q <= '0;
			chan_q  <= '0;
		end else if (adv) begin
			quiet_q <= quiet_d;
			count_q <= count_d;
			chan_q  <= chan_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++)
				totals_q[i] <= '0;
		end else if (adv && done) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (chan_q == pcbc_pkg::CHAN_W'(i + 1))
					totals_q[i] <= new_total;
			end
		end
	end

endmodule

### rtl/pulse_channel_burst_counter.sv
// Top level of the pulse channel burst counter: config, item pipeline, result register.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid / in_ready  | now_ms, active_mask
//  out     | out_valid / out_ready| pulse_counted, burst_done, done_channel,
//          |                      | done_pulses, done_total, regen_edges
//  cfg     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// One item per cycle sustained while out_ready stays high; an accepted item passes the
// input register, then one pass of debounce and burst logic, then the result register and out_valid.
// The tick state updates when the input register hands its item to the result register.
// A stall on out_ready holds the result register, then the input register, and only
// then drops in_ready. Reset clears the valid flags, tick state and channel totals and sets the
// config registers to their defaults at once, but not the data registers; there is no clearing pass.
module pulse_channel_burst_counter #(
	parameter int NUM_CHANNELS = 7
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [pcbc_pkg::TIME_W-1:0]        now_ms,
	input  logic [pcbc_pkg::MASK_W-1:0]        active_mask,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               pulse_counted,
	output logic                               burst_done,
	output logic [pcbc_pkg::CHAN_W-1:0]        done_channel,
	output logic [pcbc_pkg::COUNT_W-1:0]       done_pulses,
	output logic [pcbc_pkg::TOTAL_W-1:0]       done_total,
	output logic [pcbc_pkg::REGEN_W-1:0]       regen_edges,
	input  logic                               cfg_we,
	input  logic [pcbc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pcbc_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

	pcbc_pkg::cfg_t      cfg_q;
	pcbc_pkg::count_ev_t ev;
	pcbc_pkg::result_t   res, out_q;

	logic                         valid_s1;
	logic [pcbc_pkg::TIME_W-1:0]  now_s1;
	logic [pcbc_pkg::MASK_W-1:0]  mask_s1;
	logic                         out_valid_q;
	logic                         adv;

	// Config registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_width_ms    <= pcbc_pkg::MIN_WIDTH_RST;
			cfg_q.max_width_ms    <= pcbc_pkg::MAX_WIDTH_RST;
			cfg_q.debounce_ticks  <= pcbc_pkg::DEBOUNCE_RST;
			cfg_q.quiet_ticks     <= pcbc_pkg::QUIET_RST;
			cfg_q.passthru_enable <= 1'b1;
			cfg_q.test_mode       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcbc_pkg::REG_MIN_WIDTH: cfg_q.min_width_ms   <= cfg_wdata;
				pcbc_pkg::REG_MAX_WIDTH: cfg_q.max_width_ms   <= cfg_wdata;
				pcbc_pkg::REG_DEBOUNCE:  cfg_q.debounce_ticks <= cfg_wdata[pcbc_pkg::TICK_W-1:0];
				pcbc_pkg::REG_QUIET:     cfg_q.quiet_ticks    <= cfg_wdata[pcbc_pkg::TICK_W-1:0];
				pcbc_pkg::REG_PASSTHRU:  cfg_q.passthru_enable <= cfg_wdata[0];
				pcbc_pkg::REG_TEST_MODE: cfg_q.test_mode      <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// Advance the input item into the result register when that register is free
	// or being emptied this cycle.
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	// Input payload register; hold while stalled.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			now_s1  <= now_ms;
			mask_s1 <= active_mask;
		end
	end

	pcbc_debounce #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_debounce (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.now_ms     (now_s1),
		.active_mask(mask_s1),
		.cfg        (cfg_q),
		.ev         (ev)
	);

	pcbc_burst #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_burst (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.cfg   (cfg_q),
		.ev    (ev),
		.res   (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign pulse_counted = out_q.pulse_counted;
	assign burst_done    = out_q.burst_done;
	assign done_channel  = out_q.done_channel;
	assign done_pulses   = out_q.done_pulses;
	assign done_total    = out_q.done_total;
	assign regen_edges   = out_q.regen_edges;

`ifndef ASSERT_OFF
	// An ended burst always carries a real channel and at least one pulse.
	a_done_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && burst_done |-> done_channel != '0 && done_pulses != '0)
		else $error("burst ended with empty channel or count");

	// Without an ended burst every burst field reads zero.
	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !burst_done |-> done_channel == '0 && done_pulses == '0 &&
			done_total == '0 && regen_edges == '0)
		else $error("burst fields set without an ended burst");

	// Regeneration asks for either nothing or the pulse count shifted left by one bit.
	a_regen_twice: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> regen_edges == '0 || regen_edges == {done_pulses, 1'b0})
		else $error("regen edge count not twice the pulse count");

	// A held input item moves on whenever the result register frees up.
	a_pipe_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid_q |=> out_valid_q)
		else $error("input item did not advance into free result register");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for the pulse channel burst counter.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CHANNELS = 7;

	// Indexes past the register list; writes there must be dropped.
	localparam logic [pcbc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [pcbc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// Hold the pending item queue to this depth so long runs stay small in memory.
	localparam int PENDING_DEPTH = 64;

	typedef struct packed {
		logic [pcbc_pkg::TIME_W-1:0] stamp;
		logic [pcbc_pkg::MASK_W-1:0] levels;
	} tick_t;

	typedef enum logic [1:0] {READY_ALWAYS, READY_SPOTTY, READY_CHOKED} ready_mode_t;

	// Block ports
	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [pcbc_pkg::TIME_W-1:0]    now_ms = '0;
	logic [pcbc_pkg::MASK_W-1:0]    active_mask = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic                           pulse_counted;
	logic                           burst_done;
	logic [pcbc_pkg::CHAN_W-1:0]    done_channel;
	logic [pcbc_pkg::COUNT_W-1:0]   done_pulses;
	logic [pcbc_pkg::TOTAL_W-1:0]   done_total;
	logic [pcbc_pkg::REGEN_W-1:0]   regen_edges;
	logic                           cfg_we = 1'b0;
	logic [pcbc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pcbc_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;

	// Register copies as the block should hold them
	logic [pcbc_pkg::WIDTH_W-1:0] knob_min;
	logic [pcbc_pkg::WIDTH_W-1:0] knob_max;
	logic [pcbc_pkg::TICK_W-1:0]  knob_debounce;
	logic [pcbc_pkg::TICK_W-1:0]  knob_quiet;
	logic                         knob_passthru;
	logic                         knob_test;

	// Tick state as the block should hold it
	logic [pcbc_pkg::MASK_W-1:0]  settled_levels;
	logic [pcbc_pkg::MASK_W-1:0]  change_bits;
	logic                         change_pressed;
	logic [pcbc_pkg::TICK_W-1:0]  debounce_left;
	logic [pcbc_pkg::TIME_W-1:0]  press_stamp;
	logic [pcbc_pkg::CHAN_W-1:0]  pressed_chan;
	logic [pcbc_pkg::COUNT_W-1:0] burst_len;
	logic [pcbc_pkg::TICK_W-1:0]  quiet_left;
	logic [pcbc_pkg::CHAN_W-1:0]  burst_chan;
	logic [pcbc_pkg::TOTAL_W-1:0] chan_total [1:NUM_CHANNELS];

	tick_t             pending_ticks [$];
	pcbc_pkg::result_t tick_reports [$];
	int                outstanding = 0;
	int                ticks_queued = 0;
	int                fault_count = 0;
	bit                full_rate = 1'b0;

	// Stimulus generator state
	logic [pcbc_pkg::TIME_W-1:0] clock_ms;
	logic [pcbc_pkg::MASK_W-1:0] held_mask;

	// Sender and receiver pacing
	int          burst_left = 0;
	int          gap_left = 0;
	int          stall_run = 0;
	ready_mode_t stall_mode = READY_ALWAYS;

	pulse_channel_burst_counter #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.now_ms       (now_ms),
		.active_mask  (active_mask),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pulse_counted(pulse_counted),
		.burst_done   (burst_done),
		.done_channel (done_channel),
		.done_pulses  (done_pulses),
		.done_total   (done_total),
		.regen_edges  (regen_edges),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Advance the tick state by one item and queue the report it should produce.
	// The quiet timer goes first, then the debounce, exactly as the block orders them.
	task automatic tally_tick(input logic [pcbc_pkg::TIME_W-1:0] stamp,
			input logic [pcbc_pkg::MASK_W-1:0] levels);
		pcbc_pkg::result_t            rep;
		logic [pcbc_pkg::WIDTH_W-1:0] width;
		rep = '0;
		if (quiet_left != 0) begin
			quiet_left = quiet_left - 8'd1;
			if (quiet_left == 0) begin
				rep.burst_done = 1'b1;
				rep.done_channel = burst_chan;
				rep.done_pulses = burst_len;
				if (burst_chan >= 1 && burst_chan <= NUM_CHANNELS) begin
					chan_total[burst_chan] = chan_total[burst_chan] +
						pcbc_pkg::TOTAL_W'(burst_len);
					rep.done_total = chan_total[burst_chan];
				end
				if (knob_passthru && !knob_test)
					rep.regen_edges = {1'b0, burst_len} << 1;
				burst_len = '0;
			end
		end

		if (settled_levels != levels) begin
			// Restart the debounce on any change of the levels
			change_bits = settled_levels ^ levels;
			change_pressed = |(change_bits & levels);
			settled_levels = levels;
			debounce_left = knob_debounce;
		end else if (debounce_left != 0) begin
			debounce_left = debounce_left - 8'd1;
			if (debounce_left == 0) begin
				if (change_pressed) begin
					press_stamp = stamp;
					pressed_chan = '0;
				end else begin
					// Width wraps at 16 bits; bounds are strict on both sides
					width = stamp[pcbc_pkg::WIDTH_W-1:0] - press_stamp[pcbc_pkg::WIDTH_W-1:0];
					if (width > knob_min && width < knob_max) begin
						pressed_chan = '0;
						for (int i = 0; i < NUM_CHANNELS; i++)
							if (change_bits == pcbc_pkg::MASK_W'(1 << i))
								pressed_chan = pcbc_pkg::CHAN_W'(i + 1);
					end
				end
				// A stale channel from an earlier press counts again
				if (pressed_chan != 0) begin
					if (burst_len != pcbc_pkg::COUNT_MAX)
						burst_len = burst_len + 16'd1;
					quiet_left = knob_quiet;
					burst_chan = pressed_chan;
					rep.pulse_counted = 1'b1;
				end
			end
		end
		tick_reports.push_back(rep);
	endtask

	function automatic void log_fault(input string what, input pcbc_pkg::result_t got,
			input pcbc_pkg::result_t want);
		fault_count++;
		if (fault_count <= 10)
			$display({"%0t %s: got c=%0b d=%0b ch=%0d n=%0d tot=%0d rg=%0d",
				" want c=%0b d=%0b ch=%0d n=%0d tot=%0d rg=%0d"},
				$time, what, got.pulse_counted, got.burst_done, got.done_channel,
				got.done_pulses, got.done_total, got.regen_edges, want.pulse_counted,
				want.burst_done, want.done_channel, want.done_pulses, want.done_total,
				want.regen_edges);
	endfunction

	// Driver: present pending items in bursts with random gaps; predict on acceptance.
	always @(posedge clk or negedge arst_n) begin : feed
		logic  next_valid;
		tick_t next_tick;
		int    roll;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			next_valid = in_valid;
			if (in_valid && in_ready) begin
				tally_tick(now_ms, active_mask);
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (!full_rate && gap_left > 0) begin
					gap_left--;
				end else if (pending_ticks.size() > 0) begin
					next_tick = pending_ticks.pop_front();
					now_ms <= next_tick.stamp;
					active_mask <= next_tick.levels;
					next_valid = 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						// Pick the next burst; often run back to back
						burst_left = $urandom_range(1, 40);
						roll = $urandom_range(0, 9);
						if (roll < 4)
							gap_left = 0;
						else if (roll < 9)
							gap_left = $urandom_range(1, 4);
						else
							gap_left = $urandom_range(10, 20);
					end
				end
			end
			in_valid <= next_valid;
		end
	end

	// Monitor: check each accepted report against the oldest prediction; pace out_ready.
	always @(posedge clk or negedge arst_n) begin : watch
		pcbc_pkg::result_t got;
		pcbc_pkg::result_t want;
		logic              next_ready;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got.pulse_counted = pulse_counted;
				got.burst_done = burst_done;
				got.done_channel = done_channel;
				got.done_pulses = done_pulses;
				got.done_total = done_total;
				got.regen_edges = regen_edges;
				if (tick_reports.size() == 0) begin
					log_fault("report with no item outstanding", got, '0);
				end else begin
					want = tick_reports.pop_front();
					outstanding--;
					if (got !== want)
						log_fault("report mismatch", got, want);
				end
			end
			// Switch stall style at the end of each random-length run
			if (stall_run == 0) begin
				stall_mode = ready_mode_t'($urandom_range(0, 2));
				stall_run = $urandom_range(8, 60);
			end else begin
				stall_run--;
			end
			if (full_rate)
				next_ready = 1'b1;
			else case (stall_mode)
				READY_ALWAYS: next_ready = 1'b1;
				READY_SPOTTY: next_ready = ($urandom_range(0, 3) != 0);
				default:      next_ready = ($urandom_range(0, 7) == 0);
			endcase
			out_ready <= next_ready;
		end
	end

	// Queue one tick for the driver; hold off while the queue is full.
	task automatic push_tick(input logic [pcbc_pkg::TIME_W-1:0] stamp,
			input logic [pcbc_pkg::MASK_W-1:0] levels);
		while (pending_ticks.size() >= PENDING_DEPTH)
			@(posedge clk);
		pending_ticks.push_back({stamp, levels});
		outstanding++;
		ticks_queued++;
	endtask

	// Write one register and track it in the predictor.
	task automatic write_knob(input logic [pcbc_pkg::CFG_IDX_W-1:0] idx,
			input logic [pcbc_pkg::CFG_DAT_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			pcbc_pkg::REG_MIN_WIDTH: knob_min = value;
			pcbc_pkg::REG_MAX_WIDTH: knob_max = value;
			pcbc_pkg::REG_DEBOUNCE:  knob_debounce = value[pcbc_pkg::TICK_W-1:0];
			pcbc_pkg::REG_QUIET:     knob_quiet = value[pcbc_pkg::TICK_W-1:0];
			pcbc_pkg::REG_PASSTHRU:  knob_passthru = value[0];
			pcbc_pkg::REG_TEST_MODE: knob_test = value[0];
			default: ;
		endcase
	endtask

	// Write every register; junk in the unused upper bits must be ignored.
	task automatic configure(input int min_w, input int max_w, input int deb, input int quiet,
			input int pass, input int test);
		write_knob(pcbc_pkg::REG_MIN_WIDTH, pcbc_pkg::WIDTH_W'(min_w));
		write_knob(pcbc_pkg::REG_MAX_WIDTH, pcbc_pkg::WIDTH_W'(max_w));
		write_knob(pcbc_pkg::REG_DEBOUNCE, {8'($urandom), 8'(deb)});
		write_knob(pcbc_pkg::REG_QUIET, {8'($urandom), 8'(quiet)});
		write_knob(pcbc_pkg::REG_PASSTHRU, {15'($urandom), 1'(pass)});
		write_knob(pcbc_pkg::REG_TEST_MODE, {15'($urandom), 1'(test)});
	endtask

	// Wait until every queued item has been reported, then let the pipe empty.
	task automatic settle();
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One clean pulse on a channel: press, let it settle, hold, release at press + span.
	task automatic send_pulse(input int chan, input logic [pcbc_pkg::TIME_W-1:0] span,
			input int hold);
		logic [pcbc_pkg::MASK_W-1:0] bit_m;
		logic [pcbc_pkg::TIME_W-1:0] t_press;
		bit_m = pcbc_pkg::MASK_W'(1 << (chan - 1));
		held_mask = held_mask & ~bit_m;
		repeat (int'(knob_debounce) + 1) begin
			clock_ms += 32'd1;
			push_tick(clock_ms, held_mask | bit_m);
		end
		t_press = clock_ms;
		repeat (hold) begin
			clock_ms += 32'd1;
			push_tick(clock_ms, held_mask | bit_m);
		end
		repeat (int'(knob_debounce)) begin
			clock_ms += 32'd1;
			push_tick(clock_ms, held_mask);
		end
		// The settling tick of the release fixes the measured width
		clock_ms = t_press + span;
		push_tick(clock_ms, held_mask);
	endtask

	// Pick a pulse span: bound edges, inside the window, anything, and 16-bit wraps.
	function automatic logic [pcbc_pkg::TIME_W-1:0] pick_span();
		logic [pcbc_pkg::WIDTH_W-1:0] w;
		logic [pcbc_pkg::WIDTH_W-1:0] upper;
		int                           roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			w = knob_min;
		else if (roll == 1)
			w = knob_min + 16'd1;
		else if (roll == 2)
			w = knob_max - 16'd1;
		else if (roll == 3)
			w = knob_max;
		else if (roll == 4 || int'(knob_max) <= int'(knob_min) + 1)
			w = 16'($urandom);
		else
			w = 16'($urandom_range(int'(knob_min) + 1, int'(knob_max) - 1));
		upper = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'd0;
		return {upper, w};
	endfunction

	// Mostly well-formed pulses; the rest idle stretches, glitches, multi-channel moves, time jumps and raw noise.
	task automatic run_random(input int count);
		int                          stop_at;
		int                          roll;
		logic [pcbc_pkg::MASK_W-1:0] bit_m;
		stop_at = ticks_queued + count;
		while (ticks_queued < stop_at) begin
			roll = $urandom_range(0, 19);
			if (roll < 14) begin
				send_pulse($urandom_range(1, NUM_CHANNELS), pick_span(), $urandom_range(0, 3));
			end else if (roll < 16) begin
				// Quiet stretch, long enough at times to end the burst
				repeat ($urandom_range(1, int'(knob_quiet) + 2)) begin
					clock_ms += 32'd1;
					push_tick(clock_ms, held_mask);
				end
			end else if (roll == 16) begin
				repeat ($urandom_range(1, 4))
					push_tick($urandom, pcbc_pkg::MASK_W'($urandom));
			end else if (roll == 17) begin
				// Flip one channel and back before it settles
				bit_m = pcbc_pkg::MASK_W'(1 << ($urandom_range(1, NUM_CHANNELS) - 1));
				clock_ms += 32'd1;
				push_tick(clock_ms, held_mask ^ bit_m);
				clock_ms += 32'd1;
				push_tick(clock_ms, held_mask);
				repeat (int'(knob_debounce)) begin
					clock_ms += 32'($urandom_range(1, 200));
					push_tick(clock_ms, held_mask);
				end
			end else if (roll == 18) begin
				// Move several channels at once and let them settle
				held_mask = pcbc_pkg::MASK_W'($urandom) & pcbc_pkg::MASK_W'($urandom);
				repeat (int'(knob_debounce) + 1) begin
					clock_ms += 32'd1;
					push_tick(clock_ms, held_mask);
				end
			end else begin
				clock_ms = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFF0 : 32'($urandom);
			end
		end
	endtask

	initial begin : scenario
		// Start the predictor from the reset state
		knob_min = pcbc_pkg::MIN_WIDTH_RST;
		knob_max = pcbc_pkg::MAX_WIDTH_RST;
		knob_debounce = pcbc_pkg::DEBOUNCE_RST;
		knob_quiet = pcbc_pkg::QUIET_RST;
		knob_passthru = 1'b1;
		knob_test = 1'b0;
		settled_levels = '0;
		change_bits = '0;
		change_pressed = 1'b0;
		debounce_left = '0;
		press_stamp = '0;
		pressed_chan = '0;
		burst_len = '0;
		quiet_left = '0;
		burst_chan = '0;
		foreach (chan_total[i])
			chan_total[i] = '0;
		clock_ms = '0;
		held_mask = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: width bounds and pass-through stay at their reset values
		write_knob(pcbc_pkg::REG_DEBOUNCE, 16'd1);
		write_knob(pcbc_pkg::REG_QUIET, 16'd2);
		push_tick(32'd0, 7'h00);
		// Clean pulse on the top channel, then let its burst end
		push_tick(32'd100, 7'h40);
		push_tick(32'd101, 7'h40);
		push_tick(32'd150, 7'h00);
		push_tick(32'd151, 7'h00);
		push_tick(32'd152, 7'h00);
		push_tick(32'd153, 7'h00);
		// Glitch that never settles as a press; the too-wide release recounts the top channel
		push_tick(32'd300, 7'h01);
		push_tick(32'd301, 7'h00);
		push_tick(32'd900, 7'h00);
		// All channels pressed and released together: good width, no single channel
		push_tick(32'd1000, 7'h7F);
		push_tick(32'd1001, 7'h7F);
		push_tick(32'd1010, 7'h00);
		push_tick(32'd1040, 7'h00);
		// Press before the timestamp wraps, release after it
		push_tick(32'hFFFF_FFF0, 7'h02);
		push_tick(32'hFFFF_FFFF, 7'h02);
		push_tick(32'h0000_0000, 7'h00);
		push_tick(32'h0000_0030, 7'h00);
		// Width seen through the low 16 bits only
		push_tick(32'h0000_0040, 7'h04);
		push_tick(32'h0000_0041, 7'h04);
		push_tick(32'h0000_0050, 7'h00);
		push_tick(32'h0003_0056, 7'h00);
		push_tick(32'h0003_0057, 7'h00);
		push_tick(32'h0003_0058, 7'h00);
		settle();

		// Defaults written back explicitly
		configure(20, 250, 2, 100, 1, 0);
		clock_ms = $urandom;
		run_random(130);
		settle();

		// Widest window, fastest timers, test mode on, no idling on either side;
		// spare indexes must do nothing
		configure(0, 65535, 1, 1, 1, 1);
		write_knob(REG_SPARE_LO, 16'($urandom));
		write_knob(REG_SPARE_HI, 16'($urandom));
		clock_ms = $urandom;
		full_rate = 1'b1;
		run_random(130);
		settle();
		full_rate = 1'b0;

		repeat (3) begin
			configure($urandom_range(0, 60),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(30, 400),
				$urandom_range(1, 4), $urandom_range(1, 40),
				$urandom_range(0, 1), $urandom_range(0, 1));
			clock_ms = $urandom;
			run_random(100);
			settle();
		end

		// Empty window and the slowest quiet timer: only a stale channel can count
		configure(65535, 0, 4, 255, 0, 0);
		held_mask = '0;
		send_pulse(5, 32'd40, 1);
		repeat (260) begin
			clock_ms += 32'd1;
			push_tick(clock_ms, held_mask);
		end
		settle();

		repeat (8) @(posedge clk);
		if (fault_count == 0 && tick_reports.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// Drop the run if it hangs
	initial begin : watchdog
		#20_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule
